// File: hw/rtl/mm128_pkg.sv
// shared types, constants and cell placement for the 128-bit montgomery multiplier
// no dependencies; imported by the cell, the reduction stage and the top level
package mm128_pkg;

  localparam int MODULUS_BITS = 128;
  localparam int LIMB_BITS    = 32;
  localparam int NUM_LIMBS    = 4;
  localparam int OPERAND_BITS = LIMB_BITS * NUM_LIMBS;
  localparam int HALF_BITS    = OPERAND_BITS / 2;
  localparam int CFG_INDEX_BITS = 8;

  // operands and modulus are cut to MODULUS_BITS, the inverse is not
  localparam logic [OPERAND_BITS-1:0] OPERAND_MASK =
    {OPERAND_BITS{1'b1}} >> (OPERAND_BITS - MODULUS_BITS);

  // cell chain: a*b (16 cells), low half times inverse (10 cells), m*N (16 cells)
  localparam int P1_CELLS  = NUM_LIMBS * NUM_LIMBS;
  localparam int P2_CELLS  = NUM_LIMBS * (NUM_LIMBS + 1) / 2;
  localparam int P3_CELLS  = NUM_LIMBS * NUM_LIMBS;
  localparam int P2_FIRST  = P1_CELLS;
  localparam int P3_FIRST  = P1_CELLS + P2_CELLS;
  localparam int NUM_CELLS = P1_CELLS + P2_CELLS + P3_CELLS;

  localparam logic MODE_MULTIPLY  = 1'b0;
  localparam logic MODE_FROM_MONT = 1'b1;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_MODULUS_LOW      = 8'd0,
    REG_MODULUS_HIGH     = 8'd1,
    REG_NEG_INVERSE_LOW  = 8'd2,
    REG_NEG_INVERSE_HIGH = 8'd3
  } mm128_reg_t;

  // where a cell sits in its multiplication
  typedef struct packed {
    logic [1:0] row;
    logic [1:0] col;
    logic       row_end;
  } mm128_pos_t;

  // one word in flight along the chain
  typedef struct packed {
    logic [NUM_LIMBS-1:0][LIMB_BITS-1:0]   x;
    logic [NUM_LIMBS-1:0][LIMB_BITS-1:0]   y;
    logic [2*NUM_LIMBS-1:0][LIMB_BITS-1:0] z;
    logic [2*NUM_LIMBS-1:0][LIMB_BITS-1:0] keep;
    logic [LIMB_BITS-1:0]                  carry;
  } mm128_item_t;

  function automatic mm128_pos_t mm128_cell_pos(input int k);
    mm128_pos_t p;
    int         r;
    p = '0;
    r = 0;
    if (k < P2_FIRST) begin
      r = k;
    end else if (k >= P3_FIRST) begin
      r = k - P3_FIRST;
    end
    if (k < P2_FIRST || k >= P3_FIRST) begin
      p.row     = 2'(r >> 2);
      p.col     = 2'(r);
      p.row_end = (p.col == 2'd3);
    end else begin
      // truncated product: only limb pairs that land in the low half
      r = k - P2_FIRST;
      case (r) inside
        [0:3]: begin
          p.row = 2'd0;
          p.col = 2'(r);
        end
        [4:6]: begin
          p.row = 2'd1;
          p.col = 2'(r - 4);
        end
        [7:8]: begin
          p.row = 2'd2;
          p.col = 2'(r - 7);
        end
        default: begin
          p.row = 2'd3;
          p.col = 2'd0;
        end
      endcase
    end
    return p;
  endfunction

endpackage

// File: hw/rtl/montgomery_multiplier_128.sv
// 128-bit montgomery multiplier: a*b*2^-128 mod N, fully pipelined along a chain of 42 mac cells
// done marks a taken word leaving the cells and reduction; one word per cycle, busy stays low
// throughput is set by the chain: every cell does one 32x32 multiply per word per cycle
// the result sits on product_* for the single cycle of done; the receiver cannot stall
// rst (synchronous) empties the pipeline and loads N = 1 and the inverse with all ones
module montgomery_multiplier_128
  import mm128_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic                      mode,
  input  logic [HALF_BITS-1:0]      a_low,
  input  logic [HALF_BITS-1:0]      a_high,
  input  logic [HALF_BITS-1:0]      b_low,
  input  logic [HALF_BITS-1:0]      b_high,
  output logic                      done,
  output logic [HALF_BITS-1:0]      product_low,
  output logic [HALF_BITS-1:0]      product_high,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [HALF_BITS-1:0]      cfg_data
);

  logic [HALF_BITS-1:0]    modulus_low;
  logic [HALF_BITS-1:0]    modulus_high;
  logic [HALF_BITS-1:0]    neg_inverse_low;
  logic [HALF_BITS-1:0]    neg_inverse_high;
  logic [OPERAND_BITS-1:0] n_masked;

  mm128_item_t stage       [0:NUM_CELLS];
  logic        stage_valid [0:NUM_CELLS];
  mm128_item_t cell_in     [0:NUM_CELLS-1];
  mm128_item_t remap_ni;
  mm128_item_t remap_n;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign n_masked  = {modulus_high, modulus_low} & OPERAND_MASK;

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus_low      <= 64'd1;
      modulus_high     <= '0;
      neg_inverse_low  <= '1;
      neg_inverse_high <= '1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_MODULUS_LOW:      modulus_low      <= cfg_data;
        REG_MODULUS_HIGH:     modulus_high     <= cfg_data;
        REG_NEG_INVERSE_LOW:  neg_inverse_low  <= cfg_data;
        REG_NEG_INVERSE_HIGH: neg_inverse_high <= cfg_data;
        default: ;
      endcase
    end
  end

  // entry word for a*b
  always_comb begin
    stage[0]       = '0;
    stage[0].x     = {a_high, a_low} & OPERAND_MASK;
    stage[0].y     = (mode == MODE_FROM_MONT) ? OPERAND_BITS'(1)
                                              : ({b_high, b_low} & OPERAND_MASK);
    stage_valid[0] = start && !busy;
  end

  // hand-over between products: T is kept, its low half (then m) becomes the new x
  always_comb begin
    remap_ni      = '0;
    remap_ni.x    = stage[P2_FIRST].z[NUM_LIMBS-1:0];
    remap_ni.y    = {neg_inverse_high, neg_inverse_low};
    remap_ni.keep = stage[P2_FIRST].z;
    remap_n       = '0;
    remap_n.x     = stage[P3_FIRST].z[NUM_LIMBS-1:0];
    remap_n.y     = n_masked;
    remap_n.keep  = stage[P3_FIRST].keep;
  end

  for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
    if (k == P2_FIRST) begin : g_ni
      assign cell_in[k] = remap_ni;
    end else if (k == P3_FIRST) begin : g_n
      assign cell_in[k] = remap_n;
    end else begin : g_pass
      assign cell_in[k] = stage[k];
    end

    mm128_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .pos      (mm128_cell_pos(k)),
      .valid_in (stage_valid[k]),
      .item_in  (cell_in[k]),
      .valid    (stage_valid[k+1]),
      .item     (stage[k+1])
    );
  end

  mm128_reduce u_reduce (
    .clk          (clk),
    .rst          (rst),
    .valid_in     (stage_valid[NUM_CELLS]),
    .item_in      (stage[NUM_CELLS]),
    .n            (n_masked),
    .done         (done),
    .product_low  (product_low),
    .product_high (product_high)
  );

endmodule

// File: hw/rtl/mm128_cell.sv
// one multiply-accumulate cell of the chain: z[row+col] += x[row]*y[col] + carry
// depends on mm128_pkg
module mm128_cell
  import mm128_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  mm128_pos_t  pos,
  input  logic        valid_in,
  input  mm128_item_t item_in,
  output logic        valid,
  output mm128_item_t item
);

  logic [2:0]           zi;
  logic [LIMB_BITS-1:0] carry_in;
  logic [63:0]          prod;
  logic [63:0]          acc;
  mm128_item_t          item_next;

  always_comb begin
    zi       = {1'b0, pos.row} + {1'b0, pos.col};
    // each row starts with a clean carry
    carry_in = (pos.col == 2'd0) ? '0 : item_in.carry;
    prod     = {32'b0, item_in.x[pos.row]} * {32'b0, item_in.y[pos.col]};
    acc      = prod + {32'b0, item_in.z[zi]} + {32'b0, carry_in};
    item_next            = item_in;
    item_next.z[zi]      = acc[31:0];
    item_next.carry      = acc[63:32];
    if (pos.row_end) begin
      item_next.z[{1'b1, pos.row}] = acc[63:32];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_in;
    end
    item <= item_next;
  end

endmodule

// File: hw/rtl/mm128_reduce.sv
// final stages: U = T + m*N, keep the upper 129 bits, subtract N once if needed
// depends on mm128_pkg
module mm128_reduce
  import mm128_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    valid_in,
  input  mm128_item_t             item_in,
  input  logic [OPERAND_BITS-1:0] n,
  output logic                    done,
  output logic [HALF_BITS-1:0]    product_low,
  output logic [HALF_BITS-1:0]    product_high
);

  logic [OPERAND_BITS:0]   lo_sum;
  logic                    v1;
  logic                    c1;
  logic [OPERAND_BITS-1:0] t_hi;
  logic [OPERAND_BITS-1:0] p_hi;
  logic [OPERAND_BITS:0]   r_next;
  logic                    v2;
  logic [OPERAND_BITS:0]   r;
  logic [OPERAND_BITS+1:0] diff;
  logic [OPERAND_BITS-1:0] result;

  always_comb begin
    lo_sum = {1'b0, item_in.keep[NUM_LIMBS-1:0]} + {1'b0, item_in.z[NUM_LIMBS-1:0]};
    r_next = {1'b0, t_hi} + {1'b0, p_hi} + {{OPERAND_BITS{1'b0}}, c1};
    // no borrow out means r is at least n
    diff   = {1'b0, r} - {2'b0, n};
    result = diff[OPERAND_BITS+1] ? r[OPERAND_BITS-1:0] : diff[OPERAND_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      done <= 1'b0;
    end else begin
      v1   <= valid_in;
      v2   <= v1;
      done <= v2;
    end
    c1           <= lo_sum[OPERAND_BITS];
    t_hi         <= item_in.keep[2*NUM_LIMBS-1:NUM_LIMBS];
    p_hi         <= item_in.z[2*NUM_LIMBS-1:NUM_LIMBS];
    r            <= r_next;
    product_low  <= result[HALF_BITS-1:0];
    product_high <= result[OPERAND_BITS-1:HALF_BITS];
  end

endmodule

// File: test/testbench.sv
// self-checking bench for montgomery_multiplier_128: random and directed operand words
// checked against an in-bench a*b*2^-128 mod N predictor under several modulus settings
// depends on mm128_pkg and the montgomery_multiplier_128 top level only
module testbench;
  import mm128_pkg::*;

  localparam int CLK_PERIOD     = 10;
  localparam int RESET_CYCLES   = 8;
  localparam int SETTLE_CYCLES  = 60;
  localparam int DRAIN_LIMIT    = 2000;
  localparam int TIMEOUT_CYCLES = 200000;
  localparam int RANDOM_PHASES  = 8;
  localparam int PHASE_WORDS    = 100;

  localparam logic [CFG_INDEX_BITS-1:0] REG_INDEX_PAST_END = 8'd4;
  localparam logic [CFG_INDEX_BITS-1:0] REG_INDEX_ALL_ONES = 8'hFF;
  localparam logic [OPERAND_BITS-1:0]   ALL_ONES           = {OPERAND_BITS{1'b1}};

  typedef enum logic [1:0] {
    JOB_MULT,
    JOB_REG_WRITE,
    JOB_DRAIN
  } job_kind_t;

  typedef struct packed {
    job_kind_t                 kind;
    logic                      mode;
    logic [OPERAND_BITS-1:0]   a;
    logic [OPERAND_BITS-1:0]   b;
    logic [CFG_INDEX_BITS-1:0] index;
    logic [HALF_BITS-1:0]      data;
    logic [15:0]               gap;
  } job_t;

  typedef struct packed {
    logic [OPERAND_BITS-1:0] value;
    logic [31:0]             num;
  } product_t;

  logic                      clk          = 1'b0;
  logic                      rst          = 1'b1;
  logic                      start        = 1'b0;
  logic                      busy;
  logic                      mode         = MODE_MULTIPLY;
  logic [HALF_BITS-1:0]      a_low        = '0;
  logic [HALF_BITS-1:0]      a_high       = '0;
  logic [HALF_BITS-1:0]      b_low        = '0;
  logic [HALF_BITS-1:0]      b_high       = '0;
  logic                      done;
  logic [HALF_BITS-1:0]      product_low;
  logic [HALF_BITS-1:0]      product_high;
  logic                      cfg_valid    = 1'b0;
  logic                      cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index    = '0;
  logic [HALF_BITS-1:0]      cfg_data     = '0;

  job_t     jobs[$];
  product_t products_due[$];

  logic [OPERAND_BITS-1:0] shadow_modulus     = 128'd1;
  logic [OPERAND_BITS-1:0] shadow_neg_inverse = ALL_ONES;

  int unsigned words_sent      = 0;
  int unsigned from_mont_words = 0;
  int unsigned regs_written    = 0;
  int unsigned settings_used   = 1;
  int unsigned products_seen   = 0;
  int unsigned mismatches      = 0;
  int unsigned hold_off        = 0;

  montgomery_multiplier_128 dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .mode         (mode),
    .a_low        (a_low),
    .a_high       (a_high),
    .b_low        (b_low),
    .b_high       (b_high),
    .done         (done),
    .product_low  (product_low),
    .product_high (product_high),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #(CLK_PERIOD / 2) clk = 1'b1;
    #(CLK_PERIOD / 2) clk = 1'b0;
  end

  // a*b*2^-128 mod N with one conditional subtraction; the carry out of T + m*N is kept
  function automatic logic [OPERAND_BITS-1:0] mont_product(
    input logic                    op_mode,
    input logic [OPERAND_BITS-1:0] a,
    input logic [OPERAND_BITS-1:0] b,
    input logic [OPERAND_BITS-1:0] n,
    input logic [OPERAND_BITS-1:0] ni
  );
    logic [OPERAND_BITS-1:0]   am;
    logic [OPERAND_BITS-1:0]   bm;
    logic [OPERAND_BITS-1:0]   nm;
    logic [2*OPERAND_BITS-1:0] t;
    logic [OPERAND_BITS-1:0]   q;
    logic [2*OPERAND_BITS:0]   u;
    logic [OPERAND_BITS:0]     r;
    am = a & OPERAND_MASK;
    nm = n & OPERAND_MASK;
    bm = (op_mode == MODE_FROM_MONT) ? 128'd1 : (b & OPERAND_MASK);
    t  = {128'd0, am} * {128'd0, bm};
    q  = t[OPERAND_BITS-1:0] * ni;
    u  = {1'b0, t} + {129'd0, q} * {129'd0, nm};
    r  = u[2*OPERAND_BITS:OPERAND_BITS];
    if (r >= {1'b0, nm}) begin
      r = r - {1'b0, nm};
    end
    return r[OPERAND_BITS-1:0];
  endfunction

  // -n^-1 mod 2^128 by newton steps, each doubling the correct low bits
  function automatic logic [OPERAND_BITS-1:0] neg_inverse_of(input logic [OPERAND_BITS-1:0] n);
    logic [OPERAND_BITS-1:0] x;
    x = n;
    repeat (7) x = x * (128'd2 - n * x);
    return ~x + 128'd1;
  endfunction

  function automatic logic [OPERAND_BITS-1:0] rand128();
    return {$urandom, $urandom, $urandom, $urandom};
  endfunction

  // mostly below N, with the edges and a share of out-of-range operands
  function automatic logic [OPERAND_BITS-1:0] pick_operand(input logic [OPERAND_BITS-1:0] n);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 75) return (n == 0) ? rand128() : rand128() % n;
    if (r < 82) return '0;
    if (r < 88) return n - 128'd1;
    if (r < 92) return n;
    if (r < 96) return ALL_ONES;
    return rand128();
  endfunction

  function automatic logic [15:0] pick_gap(input logic gapped);
    int unsigned r;
    if (!gapped) return 16'd0;
    r = $urandom_range(0, 99);
    if (r < 60) return 16'd0;
    if (r < 90) return 16'($urandom_range(1, 3));
    if (r < 97) return 16'($urandom_range(4, 12));
    return 16'($urandom_range(20, 60));
  endfunction

  task automatic report_mismatch(input string what, input logic [HALF_BITS-1:0] got,
                                 input logic [HALF_BITS-1:0] want);
    $display("mismatch: %s at product %0d: got %h, want %h", what, products_seen, got, want);
    mismatches++;
  endtask

  task automatic push_mult(input logic m, input logic [OPERAND_BITS-1:0] a,
                           input logic [OPERAND_BITS-1:0] b, input logic [15:0] gap);
    job_t j;
    j       = '0;
    j.kind  = JOB_MULT;
    j.mode  = m;
    j.a     = a;
    j.b     = b;
    j.gap   = gap;
    jobs.push_back(j);
  endtask

  task automatic push_reg(input logic [CFG_INDEX_BITS-1:0] idx, input logic [HALF_BITS-1:0] data);
    job_t j;
    j       = '0;
    j.kind  = JOB_REG_WRITE;
    j.index = idx;
    j.data  = data;
    j.gap   = 16'($urandom_range(0, 2));
    jobs.push_back(j);
  endtask

  task automatic push_drain();
    job_t j;
    j      = '0;
    j.kind = JOB_DRAIN;
    jobs.push_back(j);
  endtask

  // registers change only once the pipeline has emptied
  task automatic queue_setting(input logic [OPERAND_BITS-1:0] n,
                               input logic [OPERAND_BITS-1:0] ni);
    push_drain();
    push_reg(REG_MODULUS_LOW, n[HALF_BITS-1:0]);
    push_reg(REG_MODULUS_HIGH, n[OPERAND_BITS-1:HALF_BITS]);
    push_reg(REG_NEG_INVERSE_LOW, ni[HALF_BITS-1:0]);
    push_reg(REG_NEG_INVERSE_HIGH, ni[OPERAND_BITS-1:HALF_BITS]);
    settings_used++;
  endtask

  // driver: one word or register write presented at a time, predictions made on acceptance
  always @(posedge clk) begin : drive
    job_t     j;
    product_t p;
    logic     slot_free;
    logic     next_start;
    logic     next_cfg;
    if (rst) begin
      start              <= 1'b0;
      cfg_valid          <= 1'b0;
      shadow_modulus     = 128'd1;
      shadow_neg_inverse = ALL_ONES;
      hold_off           = 0;
    end else begin
      slot_free = 1'b1;
      if (start) begin
        if (!busy) begin
          p.value = mont_product(mode, {a_high, a_low}, {b_high, b_low},
                                 shadow_modulus, shadow_neg_inverse);
          p.num   = words_sent;
          products_due.push_back(p);
          words_sent++;
          if (mode == MODE_FROM_MONT) from_mont_words++;
        end else begin
          slot_free = 1'b0;
        end
      end
      if (cfg_valid) begin
        if (cfg_ready) begin
          case (cfg_index)
            REG_MODULUS_LOW:      shadow_modulus[HALF_BITS-1:0]                 = cfg_data;
            REG_MODULUS_HIGH:     shadow_modulus[OPERAND_BITS-1:HALF_BITS]      = cfg_data;
            REG_NEG_INVERSE_LOW:  shadow_neg_inverse[HALF_BITS-1:0]             = cfg_data;
            REG_NEG_INVERSE_HIGH: shadow_neg_inverse[OPERAND_BITS-1:HALF_BITS]  = cfg_data;
            default: ;
          endcase
          regs_written++;
        end else begin
          slot_free = 1'b0;
        end
      end
      if (slot_free) begin
        next_start = 1'b0;
        next_cfg   = 1'b0;
        if (hold_off != 0) begin
          hold_off = hold_off - 1;
        end else if (jobs.size() != 0) begin
          j = jobs[0];
          if (j.gap != 0) begin
            hold_off = j.gap - 1;
            j = jobs.pop_front();
            j.gap = 0;
            jobs.push_front(j);
          end else begin
            case (j.kind)
              JOB_MULT: begin
                next_start = 1'b1;
                mode   <= j.mode;
                a_low  <= j.a[HALF_BITS-1:0];
                a_high <= j.a[OPERAND_BITS-1:HALF_BITS];
                b_low  <= j.b[HALF_BITS-1:0];
                b_high <= j.b[OPERAND_BITS-1:HALF_BITS];
                j = jobs.pop_front();
              end
              JOB_REG_WRITE: begin
                next_cfg = 1'b1;
                cfg_index <= j.index;
                cfg_data  <= j.data;
                j = jobs.pop_front();
              end
              default: begin
                if (products_due.size() == 0) begin
                  hold_off = SETTLE_CYCLES;
                  j = jobs.pop_front();
                end
              end
            endcase
          end
        end
        start     <= next_start;
        cfg_valid <= next_cfg;
      end
    end
  end

  // monitor: every done cycle carries one result, compared with the oldest prediction
  always @(posedge clk) begin : watch
    product_t want;
    if (!rst && done === 1'b1) begin
      if (products_due.size() == 0) begin
        report_mismatch("result with nothing due", product_low, '0);
      end else begin
        want = products_due.pop_front();
        if (product_low !== want.value[HALF_BITS-1:0])
          report_mismatch("product_low", product_low, want.value[HALF_BITS-1:0]);
        if (product_high !== want.value[OPERAND_BITS-1:HALF_BITS])
          report_mismatch("product_high", product_high, want.value[OPERAND_BITS-1:HALF_BITS]);
      end
      products_seen++;
    end
  end

  initial begin : stimulus
    logic [OPERAND_BITS-1:0] n;
    logic [OPERAND_BITS-1:0] ni;
    logic                    gapped;
    int                      waited;

    // reset setting: N = 1 with its true inverse
    push_mult(MODE_MULTIPLY, '0, '0, 16'd0);
    push_mult(MODE_MULTIPLY, ALL_ONES, ALL_ONES, 16'd0);
    push_mult(MODE_FROM_MONT, ALL_ONES, rand128(), 16'd0);

    n = ALL_ONES;
    queue_setting(n, neg_inverse_of(n));
    push_mult(MODE_MULTIPLY, n - 128'd1, n - 128'd1, 16'd0);
    push_mult(MODE_MULTIPLY, '0, n - 128'd1, 16'd0);
    push_mult(MODE_FROM_MONT, n - 128'd1, '0, 16'd0);
    push_mult(MODE_MULTIPLY, n, 128'd1, 16'd0);

    // modulus above 2^127 needs the top carry
    n = {1'b1, 127'(rand128())} | 128'd1;
    queue_setting(n, neg_inverse_of(n));
    push_mult(MODE_MULTIPLY, n - 128'd1, n - 128'd1, 16'd0);
    push_mult(MODE_MULTIPLY, n - 128'd1, 128'd1, 16'd0);
    push_mult(MODE_FROM_MONT, rand128() % n, ALL_ONES, 16'd0);

    n = 128'd3;
    queue_setting(n, neg_inverse_of(n));
    push_mult(MODE_MULTIPLY, 128'd2, 128'd2, 16'd0);
    push_mult(MODE_MULTIPLY, ALL_ONES, ALL_ONES, 16'd0);

    // even modulus with an arbitrary inverse
    queue_setting(rand128() & ~128'd1, rand128());
    push_mult(MODE_MULTIPLY, rand128(), rand128(), 16'd0);
    push_mult(MODE_FROM_MONT, rand128(), rand128(), 16'd0);

    // zero modulus: the subtraction takes nothing off
    queue_setting('0, rand128());
    push_mult(MODE_MULTIPLY, ALL_ONES, ALL_ONES, 16'd0);
    push_mult(MODE_MULTIPLY, rand128(), rand128(), 16'd0);

    // writes past the last register must leave the setting alone
    n = rand128() | 128'd1;
    queue_setting(n, neg_inverse_of(n));
    push_reg(REG_INDEX_PAST_END, HALF_BITS'(rand128()));
    push_reg(REG_INDEX_ALL_ONES, HALF_BITS'(rand128()));
    push_mult(MODE_MULTIPLY, rand128() % n, rand128() % n, 16'd0);
    push_mult(MODE_FROM_MONT, rand128() % n, '0, 16'd0);

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case ($urandom_range(0, 9))
        6: begin
          n  = {1'b1, 127'(rand128())} | 128'd1;
          ni = neg_inverse_of(n);
        end
        7: begin
          n  = ALL_ONES;
          ni = neg_inverse_of(n);
        end
        8: begin
          n  = rand128() | 128'd1;
          ni = rand128();
        end
        9: begin
          n  = rand128() & ~128'd1;
          ni = rand128();
        end
        default: begin
          n  = (rand128() >> $urandom_range(0, 127)) | 128'd1;
          ni = neg_inverse_of(n);
        end
      endcase
      queue_setting(n, ni);
      gapped = (ph % 3) != 0;
      for (int k = 0; k < PHASE_WORDS; k++) begin
        // now and then the sender waits for the pipeline to empty
        if ($urandom_range(0, 59) == 0) push_drain();
        push_mult(($urandom_range(0, 9) < 7) ? MODE_MULTIPLY : MODE_FROM_MONT,
                  pick_operand(n), pick_operand(n), pick_gap(gapped));
      end
    end

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    while (jobs.size() != 0 || start || cfg_valid) @(posedge clk);
    for (waited = 0; waited < DRAIN_LIMIT && products_due.size() != 0; waited++)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (products_due.size() != 0)
      report_mismatch("products never returned", HALF_BITS'(products_due.size()), '0);

    $display("covered %0d words (%0d out of montgomery form) over %0d modulus settings",
             words_sent, from_mont_words, settings_used);
    $display("%0d register writes, %0d products checked, %0d mismatches",
             regs_written, products_seen, mismatches);
    if (mismatches == 0) begin
      $display("PASS montgomery_multiplier_128");
    end else begin
      $display("FAIL montgomery_multiplier_128");
    end
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("timed out with %0d products outstanding", products_due.size());
    $display("FAIL montgomery_multiplier_128");
    $finish;
  end

endmodule
